[src/ocean_spectrum_time_evolution_assert.svh]
// ============================================================================
// ocean_spectrum_time_evolution_assert.svh
// Assertion macros shared by the ocean spectrum block
// ============================================================================
`ifndef OCEAN_SPECTRUM_TIME_EVOLUTION_ASSERT_SVH
`define OCEAN_SPECTRUM_TIME_EVOLUTION_ASSERT_SVH

// same-cycle implication, disabled during reset
`define OST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define OST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/ost_pkg.sv]
// ============================================================================
// ost_pkg
// Shared constants and rounding helper for the ocean spectrum block
// ============================================================================
package ost_pkg;

	// default grid size
	localparam int GRID_COLS_DEF = 256;
	localparam int GRID_ROWS_DEF = 256;

	// fixed-point constants
	localparam logic [19:0] GRAVITY_Q16    = 20'd642908;
	localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
	localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
	localparam logic [30:0] ONE_Q30        = 31'd1073741824;

	// working width of the rounding helper
	localparam int RW = 68;

	// round |v| >> sh half away from zero, saturate to signed 32 bits
	function automatic logic signed [31:0] rnd_sat(input logic signed [RW-1:0] v,
			input int unsigned sh);
		logic [RW-1:0] mag;
		logic [RW-1:0] rnd;
		logic signed [31:0] res;
		mag = v[RW-1] ? RW'(-v) : RW'(v);
		rnd = (mag + (RW'(1) << (sh - 1))) >> sh;
		if (v[RW-1]) begin
			res = (rnd > RW'(33'h080000000)) ? 32'sh80000000 : -$signed(rnd[31:0]);
		end else begin
			res = (rnd > RW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(rnd[31:0]);
		end
		return res;
	endfunction

endpackage

[src/ost_delay.sv]
// ============================================================================
// ost_delay
// Enabled shift line that carries side data along the pipeline
// ============================================================================
module ost_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_s [N];

	// shift on every pipeline advance
	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= din;
			for (int i = 1; i < N; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign dout = tap_s[N-1];

endmodule

[src/ost_isqrt.sv]
// ============================================================================
// ost_isqrt
// Pipelined integer square root, one result bit per stage
// ============================================================================
module ost_isqrt #(
	parameter int IW = 64
) (
	input  logic            clk,
	input  logic            en,
	input  logic [IW-1:0]   din,
	output logic [IW/2-1:0] dout
);

	localparam int H = IW / 2;

	logic [IW-1:0] rem_s [H];
	logic [IW-1:0] res_s [H];

	for (genvar gi = 0; gi < H; gi++) begin : g_stage
		localparam logic [IW-1:0] BIT = IW'(1) << (IW - 2 - 2 * gi);
		logic [IW-1:0] rem_in;
		logic [IW-1:0] res_in;
		logic [IW-1:0] trial;

		if (gi == 0) begin : g_first
			assign rem_in = din;
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[gi-1];
			assign res_in = res_s[gi-1];
		end

		assign trial = res_in + BIT;

		// one trial subtract per stage
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[gi] <= rem_in - trial;
					res_s[gi] <= (res_in >> 1) + BIT;
				end else begin
					rem_s[gi] <= rem_in;
					res_s[gi] <= res_in >> 1;
				end
			end
		end
	end

	assign dout = res_s[H-1][H-1:0];

endmodule

[src/ost_udiv.sv]
// ============================================================================
// ost_udiv
// Pipelined restoring divider, one quotient bit per stage
// ============================================================================
module ost_udiv #(
	parameter int NW = 49,
	parameter int DW = 32,
	parameter int QW = 17
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	logic [NW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];

	for (genvar gi = 0; gi < QW; gi++) begin : g_stage
		localparam int SH = QW - 1 - gi;
		logic [NW-1:0]    rem_in;
		logic [DW-1:0]    den_in;
		logic [QW-1:0]    quo_in;
		logic [NW+DW-1:0] dsh;

		if (gi == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[gi-1];
			assign den_in = den_s[gi-1];
			assign quo_in = quo_s[gi-1];
		end

		assign dsh = (NW+DW)'(den_in) << SH;

		// compare and subtract the shifted divisor
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[gi] <= den_in;
				if ((NW+DW)'(rem_in) >= dsh) begin
					rem_s[gi] <= rem_in - NW'(dsh);
					quo_s[gi] <= quo_in | (QW'(1) << SH);
				end else begin
					rem_s[gi] <= rem_in;
					quo_s[gi] <= quo_in;
				end
			end
		end
	end

	assign quo = quo_s[QW-1];

endmodule

[src/ost_sincos.sv]
// ============================================================================
// ost_sincos
// Pipelined Q30 sine and cosine of an angle in turns (Taylor series)
// ============================================================================
module ost_sincos
	import ost_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        ang,
	output logic signed [31:0] sn,
	output logic signed [31:0] cs
);

	// reciprocals for exact floor division of values below 2^31
	localparam int S42 = 37;
	localparam int S56 = 37;
	localparam int S20 = 36;
	localparam int S30 = 36;
	localparam int S6  = 34;
	localparam int S12 = 35;
	localparam logic [31:0] REC42 = 32'(((64'd1 << S42) + 64'd41) / 64'd42);
	localparam logic [31:0] REC56 = 32'(((64'd1 << S56) + 64'd55) / 64'd56);
	localparam logic [31:0] REC20 = 32'(((64'd1 << S20) + 64'd19) / 64'd20);
	localparam logic [31:0] REC30 = 32'(((64'd1 << S30) + 64'd29) / 64'd30);
	localparam logic [31:0] REC6  = 32'(((64'd1 << S6) + 64'd5) / 64'd6);
	localparam logic [31:0] REC12 = 32'(((64'd1 << S12) + 64'd11) / 64'd12);

	logic [1:0]  quad_s1, quad_s2, quad_s3, quad_s4, quad_s5;
	logic [1:0]  quad_s6, quad_s7, quad_s8, quad_s9, quad_s10;
	logic        swap_s1, swap_s2, swap_s3, swap_s4, swap_s5;
	logic        swap_s6, swap_s7, swap_s8, swap_s9, swap_s10;
	logic [29:0] r_s1;
	logic [29:0] x_s2, x_s3, x_s4, x_s5, x_s6, x_s7, x_s8;
	logic [29:0] x2_s3, x2_s4, x2_s5, x2_s6, x2_s7, x2_s8;
	logic [29:0] qs_s4, qc_s4, ms_s5, mc_s5, qs_s6, qc_s6;
	logic [29:0] ms_s7, mc_s7, qs_s8, qc_s8, s_s9, mc_s9;
	logic [30:0] s_s10, c_s10;
	logic [30:0] rfold;
	logic        swap_c;
	logic [60:0] px;
	logic [59:0] px2;
	logic [61:0] pqs4, pqc4, pqs6, pqc6, pqs8, pqc8;
	logic [60:0] pms5, pmc5, pms7, pmc7, ps9, pmc9;
	logic [30:0] a_val, b_val;

	// fold the angle into the first octant
	assign swap_c = ang[29:0] > 30'h20000000;
	assign rfold  = 31'h40000000 - {1'b0, ang[29:0]};

	// products of the series
	assign px   = r_s1 * HALF_PI_Q30;
	assign px2  = x_s2 * x_s2;
	assign pqs4 = x2_s3 * REC42;
	assign pqc4 = x2_s3 * REC56;
	assign pms5 = x2_s4 * (ONE_Q30 - {1'b0, qs_s4});
	assign pmc5 = x2_s4 * (ONE_Q30 - {1'b0, qc_s4});
	assign pqs6 = ms_s5 * REC20;
	assign pqc6 = mc_s5 * REC30;
	assign pms7 = x2_s6 * (ONE_Q30 - {1'b0, qs_s6});
	assign pmc7 = x2_s6 * (ONE_Q30 - {1'b0, qc_s6});
	assign pqs8 = ms_s7 * REC6;
	assign pqc8 = mc_s7 * REC12;
	assign ps9  = x_s8 * (ONE_Q30 - {1'b0, qs_s8});
	assign pmc9 = x2_s8 * (ONE_Q30 - {1'b0, qc_s8});

	// series stages
	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1  <= ang[31:30];
			swap_s1  <= swap_c;
			r_s1     <= swap_c ? rfold[29:0] : ang[29:0];
			x_s2     <= px[59:30];
			x2_s3    <= px2[59:30];
			x_s3     <= x_s2;
			qs_s4    <= 30'(pqs4 >> S42);
			qc_s4    <= 30'(pqc4 >> S56);
			ms_s5    <= pms5[59:30];
			mc_s5    <= pmc5[59:30];
			qs_s6    <= 30'(pqs6 >> S20);
			qc_s6    <= 30'(pqc6 >> S30);
			ms_s7    <= pms7[59:30];
			mc_s7    <= pmc7[59:30];
			qs_s8    <= 30'(pqs8 >> S6);
			qc_s8    <= 30'(pqc8 >> S12);
			s_s9     <= ps9[59:30];
			mc_s9    <= pmc9[59:30];
			s_s10    <= {1'b0, s_s9};
			c_s10    <= ONE_Q30 - {2'b0, mc_s9[29:1]};
			x2_s4    <= x2_s3;
			x2_s5    <= x2_s4;
			x2_s6    <= x2_s5;
			x2_s7    <= x2_s6;
			x2_s8    <= x2_s7;
			x_s4     <= x_s3;
			x_s5     <= x_s4;
			x_s6     <= x_s5;
			x_s7     <= x_s6;
			x_s8     <= x_s7;
			quad_s2  <= quad_s1;
			quad_s3  <= quad_s2;
			quad_s4  <= quad_s3;
			quad_s5  <= quad_s4;
			quad_s6  <= quad_s5;
			quad_s7  <= quad_s6;
			quad_s8  <= quad_s7;
			quad_s9  <= quad_s8;
			quad_s10 <= quad_s9;
			swap_s2  <= swap_s1;
			swap_s3  <= swap_s2;
			swap_s4  <= swap_s3;
			swap_s5  <= swap_s4;
			swap_s6  <= swap_s5;
			swap_s7  <= swap_s6;
			swap_s8  <= swap_s7;
			swap_s9  <= swap_s8;
			swap_s10 <= swap_s9;
		end
	end

	// undo the octant fold
	assign a_val = swap_s10 ? c_s10 : s_s10;
	assign b_val = swap_s10 ? s_s10 : c_s10;

	// place into the quadrant
	always_ff @(posedge clk) begin
		if (en) begin
			unique case (quad_s10)
				2'd0: begin
					sn <= $signed({1'b0, a_val});
					cs <= $signed({1'b0, b_val});
				end
				2'd1: begin
					sn <= $signed({1'b0, b_val});
					cs <= -$signed({1'b0, a_val});
				end
				2'd2: begin
					sn <= -$signed({1'b0, a_val});
					cs <= -$signed({1'b0, b_val});
				end
				default: begin
					sn <= -$signed({1'b0, b_val});
					cs <= $signed({1'b0, a_val});
				end
			endcase
		end
	end

endmodule

[src/ocean_spectrum_time_evolution.sv]
// ============================================================================
// ocean_spectrum_time_evolution
// Time evolution of FFT ocean frequency bins in Q16.16
// ============================================================================
// Takes one frequency bin per cycle while the output is not stalled and
// returns its evolved height amplitude, slopes and horizontal displacements.
// The pipeline depth is set by the two square-root pipelines (32 stages for
// |k|, 26 for omega) and the 11-stage sine/cosine series; the unit-vector
// dividers (17 stages) run beside the omega path. A stalled output freezes
// the whole pipeline, so nothing is lost or repeated. Configuration writes
// are taken at any time and should be made while the pipeline is empty.
`include "ocean_spectrum_time_evolution_assert.svh"

module ocean_spectrum_time_evolution
	import ost_pkg::*;
#(
	parameter int GRID_COLS = GRID_COLS_DEF,
	parameter int GRID_ROWS = GRID_ROWS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream: col_index, row_index, h0_re, h0_im, mirror_re, mirror_im
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [143:0] s_tdata,
	// output stream: h_re, h_im, slope_x_re, slope_x_im, slope_z_re,
	// slope_z_im, disp_x_re, disp_x_im, disp_z_re, disp_z_im
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [319:0] m_tdata,
	// configuration writes
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	// register indexes
	localparam logic [1:0] REG_WAVE_STEP_X = 2'd0;
	localparam logic [1:0] REG_WAVE_STEP_Z = 2'd1;
	localparam logic [1:0] REG_SIM_TIME    = 2'd2;

	// stage positions
	localparam int LAT    = 82;
	localparam int P_K    = 2;
	localparam int P_KLEN = 36;
	localparam int P_G    = 37;
	localparam int P_QDIV = 54;
	localparam int P_U    = 55;
	localparam int P_SC   = 77;
	localparam int P_H    = 80;

	// centred index widths
	localparam int CXB = ($clog2(GRID_COLS) > 8) ? $clog2(GRID_COLS) : 8;
	localparam int CZB = ($clog2(GRID_ROWS) > 8) ? $clog2(GRID_ROWS) : 8;
	localparam int CXW = CXB + 2;
	localparam int CZW = CZB + 2;

	localparam logic signed [31:0] ONE_S = 32'sd1073741824;

	logic [31:0] wave_step_x_q, wave_step_z_q, sim_time_q;
	logic [LAT-1:0] vld_q;
	logic en;

	logic signed [CXW-1:0]  cn_x;
	logic signed [CZW-1:0]  cn_z;
	logic signed [CXW+32:0] px_c;
	logic signed [CZW+32:0] pz_c;
	logic signed [CXW+32:0] px_s1;
	logic signed [CZW+32:0] pz_s1;
	logic signed [31:0] kx_s2, kz_s2;
	logic signed [63:0] sqx_c, sqz_c;
	logic [63:0] kxsq_s3, kzsq_s3, ksum_s4;
	logic [31:0] klen;
	logic [63:0] k_d36;
	logic signed [31:0] kx_d36, kz_d36;
	logic [31:0] magx, magz;
	logic [51:0] gprod;
	logic [51:0] gk_s37;
	logic [48:0] numx_s37, numz_s37;
	logic [31:0] klen_s37;
	logic [2:0]  side_s37, side_d54;
	logic [16:0] qx, qz;
	logic signed [31:0] ux_s55, uz_s55;
	logic [63:0] u_d80, k_d80;
	logic [25:0] omega;
	logic [57:0] ph_c, ph_s64;
	logic [55:0] pa_c;
	logic [61:0] pb_c;
	logic [31:0] pa_s65;
	logic [29:0] pb_s65;
	logic [31:0] ang_s66;
	logic signed [31:0] sn_s77, cs_s77;
	logic [127:0] amp_d77;
	logic signed [31:0] h0r, h0i, mr, mi;
	logic signed [63:0] pa, pb, pc, pd, pe, pf, pg, ph;
	logic signed [63:0] pa_s78, pb_s78, pc_s78, pd_s78;
	logic signed [63:0] pe_s78, pf_s78, pg_s78, ph_s78;
	logic signed [64:0] r1_s79, r2_s79, i1_s79, i2_s79;
	logic signed [31:0] hr_s80, hi_s80, hr_s81, hi_s81;
	logic signed [31:0] kx80, kz80, ux80, uz80;
	logic signed [63:0] m_kxhi, m_kxhr, m_kzhi, m_kzhr;
	logic signed [63:0] m_uxhi, m_uxhr, m_uzhi, m_uzhr;
	logic signed [63:0] kxhi_s81, kxhr_s81, kzhi_s81, kzhr_s81;
	logic signed [63:0] uxhi_s81, uxhr_s81, uzhi_s81, uzhr_s81;
	logic [319:0] data_s82;

	// handshake: the whole pipeline advances when the output can move
	assign en        = !vld_q[LAT-1] || m_tready;
	assign s_tready  = en;
	assign m_tvalid  = vld_q[LAT-1];
	assign m_tdata   = data_s82;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_step_x_q <= 32'd1647099;
			wave_step_z_q <= 32'd1647099;
			sim_time_q    <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WAVE_STEP_X: wave_step_x_q <= cfg_data;
				REG_WAVE_STEP_Z: wave_step_z_q <= cfg_data;
				REG_SIM_TIME:    sim_time_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// wave vector
	assign cn_x  = $signed(CXW'({1'b0, s_tdata[7:0]})) - $signed(CXW'(GRID_COLS / 2));
	assign cn_z  = $signed(CZW'({1'b0, s_tdata[15:8]})) - $signed(CZW'(GRID_ROWS / 2));
	assign px_c  = cn_x * $signed({1'b0, wave_step_x_q});
	assign pz_c  = cn_z * $signed({1'b0, wave_step_z_q});
	assign sqx_c = kx_s2 * kx_s2;
	assign sqz_c = kz_s2 * kz_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= px_c;
			pz_s1   <= pz_c;
			kx_s2   <= rnd_sat(RW'(px_s1), 8);
			kz_s2   <= rnd_sat(RW'(pz_s1), 8);
			kxsq_s3 <= $unsigned(sqx_c);
			kzsq_s3 <= $unsigned(sqz_c);
			ksum_s4 <= kxsq_s3 + kzsq_s3;
		end
	end

	// length of k
	ost_isqrt #(.IW(64)) u_sqrt_k (
		.clk (clk),
		.en  (en),
		.din (ksum_s4),
		.dout(klen)
	);

	ost_delay #(.W(64), .N(P_KLEN - P_K)) u_dly_k1 (
		.clk (clk),
		.en  (en),
		.din ({kz_s2, kx_s2}),
		.dout(k_d36)
	);

	assign kx_d36 = $signed(k_d36[31:0]);
	assign kz_d36 = $signed(k_d36[63:32]);
	assign magx   = kx_d36[31] ? 32'(-kx_d36) : 32'(kx_d36);
	assign magz   = kz_d36[31] ? 32'(-kz_d36) : 32'(kz_d36);
	assign gprod  = klen * GRAVITY_Q16;

	// dispersion input and unit-vector numerators
	always_ff @(posedge clk) begin
		if (en) begin
			gk_s37   <= gprod;
			numx_s37 <= 49'({magx, 16'd0}) + 49'(klen >> 1);
			numz_s37 <= 49'({magz, 16'd0}) + 49'(klen >> 1);
			klen_s37 <= klen;
			side_s37 <= {kx_d36[31], kz_d36[31], klen == 32'd0};
		end
	end

	ost_isqrt #(.IW(52)) u_sqrt_w (
		.clk (clk),
		.en  (en),
		.din (gk_s37),
		.dout(omega)
	);

	ost_udiv #(.NW(49), .DW(32), .QW(17)) u_div_x (
		.clk(clk),
		.en (en),
		.num(numx_s37),
		.den(klen_s37),
		.quo(qx)
	);

	ost_udiv #(.NW(49), .DW(32), .QW(17)) u_div_z (
		.clk(clk),
		.en (en),
		.num(numz_s37),
		.den(klen_s37),
		.quo(qz)
	);

	ost_delay #(.W(3), .N(P_QDIV - P_G)) u_dly_side (
		.clk (clk),
		.en  (en),
		.din (side_s37),
		.dout(side_d54)
	);

	// signed unit vector, zero when k is zero
	always_ff @(posedge clk) begin
		if (en) begin
			if (side_d54[0]) begin
				ux_s55 <= '0;
				uz_s55 <= '0;
			end else begin
				ux_s55 <= side_d54[2] ? -$signed(32'(qx)) : $signed(32'(qx));
				uz_s55 <= side_d54[1] ? -$signed(32'(qz)) : $signed(32'(qz));
			end
		end
	end

	ost_delay #(.W(64), .N(P_H - P_U)) u_dly_u (
		.clk (clk),
		.en  (en),
		.din ({uz_s55, ux_s55}),
		.dout(u_d80)
	);

	ost_delay #(.W(64), .N(P_H - P_KLEN)) u_dly_k2 (
		.clk (clk),
		.en  (en),
		.din (k_d36),
		.dout(k_d80)
	);

	// phase angle in turns
	assign ph_c = omega * sim_time_q;
	assign pa_c = ph_s64[57:32] * INV_TWO_PI_Q32;
	assign pb_c = ph_s64[31:0] * INV_TWO_PI_Q32;

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s64  <= ph_c;
			pa_s65  <= pa_c[31:0];
			pb_s65  <= pb_c[61:32];
			ang_s66 <= pa_s65 + {2'b0, pb_s65};
		end
	end

	ost_sincos u_sincos (
		.clk(clk),
		.en (en),
		.ang(ang_s66),
		.sn (sn_s77),
		.cs (cs_s77)
	);

	ost_delay #(.W(128), .N(P_SC)) u_dly_amp (
		.clk (clk),
		.en  (en),
		.din (s_tdata[143:16]),
		.dout(amp_d77)
	);

	// rotation of h0 and the conjugate term
	assign h0r = $signed(amp_d77[31:0]);
	assign h0i = $signed(amp_d77[63:32]);
	assign mr  = $signed(amp_d77[95:64]);
	assign mi  = $signed(amp_d77[127:96]);
	assign pa  = h0r * cs_s77;
	assign pb  = h0i * sn_s77;
	assign pc  = mr * cs_s77;
	assign pd  = mi * sn_s77;
	assign pe  = h0r * sn_s77;
	assign pf  = h0i * cs_s77;
	assign pg  = mi * cs_s77;
	assign ph  = mr * sn_s77;

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s78 <= pa;
			pb_s78 <= pb;
			pc_s78 <= pc;
			pd_s78 <= pd;
			pe_s78 <= pe;
			pf_s78 <= pf;
			pg_s78 <= pg;
			ph_s78 <= ph;
			r1_s79 <= 65'(pa_s78) - 65'(pb_s78);
			r2_s79 <= 65'(pc_s78) + 65'(pd_s78);
			i1_s79 <= 65'(pe_s78) + 65'(pf_s78);
			i2_s79 <= 65'(pg_s78) - 65'(ph_s78);
			hr_s80 <= rnd_sat(RW'(r1_s79) + RW'(r2_s79), 30);
			hi_s80 <= rnd_sat(RW'(i1_s79) + RW'(i2_s79), 30);
		end
	end

	// slopes and displacements
	assign kx80   = $signed(k_d80[31:0]);
	assign kz80   = $signed(k_d80[63:32]);
	assign ux80   = $signed(u_d80[31:0]);
	assign uz80   = $signed(u_d80[63:32]);
	assign m_kxhi = kx80 * hi_s80;
	assign m_kxhr = kx80 * hr_s80;
	assign m_kzhi = kz80 * hi_s80;
	assign m_kzhr = kz80 * hr_s80;
	assign m_uxhi = ux80 * hi_s80;
	assign m_uxhr = ux80 * hr_s80;
	assign m_uzhi = uz80 * hi_s80;
	assign m_uzhr = uz80 * hr_s80;

	always_ff @(posedge clk) begin
		if (en) begin
			kxhi_s81 <= m_kxhi;
			kxhr_s81 <= m_kxhr;
			kzhi_s81 <= m_kzhi;
			kzhr_s81 <= m_kzhr;
			uxhi_s81 <= m_uxhi;
			uxhr_s81 <= m_uxhr;
			uzhi_s81 <= m_uzhi;
			uzhr_s81 <= m_uzhr;
			hr_s81   <= hr_s80;
			hi_s81   <= hi_s80;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			data_s82 <= {
				rnd_sat(-RW'(uzhr_s81), 16),
				rnd_sat(RW'(uzhi_s81), 16),
				rnd_sat(-RW'(uxhr_s81), 16),
				rnd_sat(RW'(uxhi_s81), 16),
				rnd_sat(RW'(kzhr_s81), 16),
				rnd_sat(-RW'(kzhi_s81), 16),
				rnd_sat(RW'(kxhr_s81), 16),
				rnd_sat(-RW'(kxhi_s81), 16),
				hi_s81,
				hr_s81
			};
		end
	end

	// checks
	`OST_ASSERT_NEXT(a_stall_freeze, m_tvalid && !m_tready, $stable(vld_q), "pipeline moved under stall")
	`OST_ASSERT_NOW(a_ready_empty, !m_tvalid, s_tready, "input blocked with empty output")
	`OST_ASSERT_NOW(a_sincos_range, vld_q[P_SC-1], (sn_s77 <= ONE_S) && (sn_s77 >= -ONE_S) && (cs_s77 <= ONE_S) && (cs_s77 >= -ONE_S), "sine or cosine out of range")

endmodule

[tb/ocean_spectrum_time_evolution_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// ocean_spectrum_time_evolution_tb
// Self-checking regression for the ocean spectrum time evolution block
// ============================================================================
// Streams frequency bins into the block under several wave-step and time
// settings, predicts each evolved bin in fixed point and compares every
// output transfer field by field. Both stream sides idle at random, the
// receiver holds off for a long stretch once, and the configuration is
// changed only while the pipeline is empty.
module ocean_spectrum_time_evolution_tb;
	import ost_pkg::*;

	localparam int        LATENCY   = 82;
	localparam int        MAX_WAIT  = 18;
	localparam longint    CYCLE_MAX = 400000;

	localparam logic [1:0] REG_STEP_X = 2'd0;
	localparam logic [1:0] REG_STEP_Z = 2'd1;
	localparam logic [1:0] REG_TIME   = 2'd2;
	localparam logic [1:0] REG_NONE   = 2'd3;

	typedef struct packed {
		logic signed [31:0] mir_im;
		logic signed [31:0] mir_re;
		logic signed [31:0] h0_im;
		logic signed [31:0] h0_re;
		logic [7:0]         row;
		logic [7:0]         col;
	} bin_t;

	typedef struct packed {
		logic signed [31:0] dz_im;
		logic signed [31:0] dz_re;
		logic signed [31:0] dx_im;
		logic signed [31:0] dx_re;
		logic signed [31:0] sz_im;
		logic signed [31:0] sz_re;
		logic signed [31:0] sx_im;
		logic signed [31:0] sx_re;
		logic signed [31:0] h_im;
		logic signed [31:0] h_re;
	} wave_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [319:0] m_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_data;

	// handshake state seen at the last rising edge
	logic s_tready_q;
	logic m_tvalid_q;

	// predictor copy of the registers
	logic [31:0] step_x_q;
	logic [31:0] step_z_q;
	logic [31:0] time_q;

	bin_t   pending_bins[$];
	wave_t  wave_expect[$];
	int     err_count = 0;
	longint cycles = 0;
	bit     idle_on;
	int     hold_tokens;
	int     hold_taken;

	ocean_spectrum_time_evolution i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // col, row, h0_re, h0_im, mirror_re, mirror_im
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // h_re, h_im, slope x/z, disp x/z (re, im each)
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// round half away from zero after the shift, saturate to 32 bits
	function automatic logic signed [31:0] round_sat(input logic signed [67:0] v,
			input int sh);
		logic [67:0] mag;
		mag = v[67] ? 68'(-v) : 68'(v);
		mag = (mag + (68'(1) << (sh - 1))) >> sh;
		if (v[67])
			return (mag > 68'h080000000) ? 32'sh80000000 : -$signed(mag[31:0]);
		return (mag > 68'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(mag[31:0]);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// k component over |k| in Q16.16, k itself at zero length
	function automatic longint unit_comp(input longint kc, input longint unsigned klen);
		longint unsigned mag;
		longint unsigned q;
		if (klen == 0)
			return kc;
		mag = (kc < 0) ? longint'(-kc) : kc;
		q   = ((mag << 16) + klen / 2) / klen;
		return (kc < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic wave_t evolve_bin(input bin_t b);
		longint          cn, cm, kx, kz, sn, cs, ux, uz;
		longint unsigned klen, omega, phase, r, x, x2, t, s, c, tmp;
		logic [31:0]     ang;
		logic [1:0]      quad;
		bit              swap;
		logic signed [67:0] hr_sum, hi_sum;
		logic signed [31:0] hr, hi;
		wave_t           w;
		cn = longint'(b.col) - 128;
		cm = longint'(b.row) - 128;
		kx = round_sat(68'(cn * longint'(step_x_q)), 8);
		kz = round_sat(68'(cm * longint'(step_z_q)), 8);
		klen  = int_sqrt(longint'(kx * kx) + longint'(kz * kz));
		omega = int_sqrt(64'd642908 * klen);
		phase = omega * longint'(time_q);
		tmp   = phase * 64'd683565276;
		ang   = tmp[63:32];
		// fold to one eighth of a turn, then Taylor series
		quad = ang[31:30];
		r    = ang[29:0];
		swap = r > 64'h20000000;
		if (swap)
			r = 64'h40000000 - r;
		x  = (r * 64'd1686629713) >> 30;
		x2 = (x * x) >> 30;
		t  = 64'd1073741824 - x2 / 42;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
		s  = (x * t) >> 30;
		t  = 64'd1073741824 - x2 / 56;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 30;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 12;
		c  = 64'd1073741824 - ((x2 * t) >> 30) / 2;
		if (swap) begin
			tmp = s;
			s   = c;
			c   = tmp;
		end
		case (quad)
			2'd0: begin sn = s;  cs = c;  end
			2'd1: begin sn = c;  cs = -longint'(s); end
			2'd2: begin sn = -longint'(s); cs = -longint'(c); end
			default: begin sn = -longint'(c); cs = s; end
		endcase
		hr_sum = 68'(b.h0_re) * 68'(cs) - 68'(b.h0_im) * 68'(sn)
			+ 68'(b.mir_re) * 68'(cs) + 68'(b.mir_im) * 68'(sn);
		hi_sum = 68'(b.h0_re) * 68'(sn) + 68'(b.h0_im) * 68'(cs)
			+ 68'(b.mir_im) * 68'(cs) - 68'(b.mir_re) * 68'(sn);
		hr = round_sat(hr_sum, 30);
		hi = round_sat(hi_sum, 30);
		ux = unit_comp(kx, klen);
		uz = unit_comp(kz, klen);
		w.h_re  = hr;
		w.h_im  = hi;
		w.sx_re = round_sat(-(68'(kx) * 68'(hi)), 16);
		w.sx_im = round_sat(68'(kx) * 68'(hr), 16);
		w.sz_re = round_sat(-(68'(kz) * 68'(hi)), 16);
		w.sz_im = round_sat(68'(kz) * 68'(hr), 16);
		w.dx_re = round_sat(68'(ux) * 68'(hi), 16);
		w.dx_im = round_sat(-(68'(ux) * 68'(hr)), 16);
		w.dz_re = round_sat(68'(uz) * 68'(hi), 16);
		w.dz_im = round_sat(-(68'(uz) * 68'(hr)), 16);
		return w;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
		err_count++;
	endtask

	// clock and run limit
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_MAX) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// input driver fed from the pending queue
	int in_gap;
	always @(negedge clk or negedge arst_n) begin
		bin_t b;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			in_gap   <= 0;
		end else if (!s_tvalid || s_tready_q) begin
			if (in_gap > 0) begin
				in_gap   <= in_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_bins.size() > 0) begin
				b = pending_bins.pop_front();
				s_tdata  <= b;
				s_tvalid <= 1'b1;
				in_gap   <= idle_on ? $urandom_range(0, MAX_WAIT) : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver backpressure, with a long hold-off on request
	int out_wait;
	int hold_left;
	always @(negedge clk or negedge arst_n) begin
		int draw;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			out_wait   <= 0;
			hold_left  <= 0;
			hold_taken <= 0;
		end else if (hold_taken != hold_tokens) begin
			hold_taken <= hold_tokens;
			hold_left  <= 400;
			m_tready   <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (m_tready && m_tvalid_q) begin
			if (idle_on) begin
				draw     = $urandom_range(0, MAX_WAIT);
				out_wait <= (draw > 0) ? draw - 1 : 0;
				m_tready <= (draw == 0);
			end
		end else if (out_wait > 0) begin
			out_wait <= out_wait - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor: predict on input transfer, check on output transfer
	always @(posedge clk) begin
		wave_t got;
		wave_t want;
		s_tready_q <= s_tready;
		m_tvalid_q <= m_tvalid;
		if (arst_n && s_tvalid && s_tready)
			wave_expect.push_back(evolve_bin(bin_t'(s_tdata)));
		if (arst_n && m_tvalid && m_tready) begin
			got = wave_t'(m_tdata);
			if (wave_expect.size() == 0) begin
				$display("unexpected output transfer at cycle %0d", cycles);
				err_count++;
			end else begin
				want = wave_expect.pop_front();
				if (got.h_re  !== want.h_re)  report_mismatch("h_re", got.h_re, want.h_re);
				if (got.h_im  !== want.h_im)  report_mismatch("h_im", got.h_im, want.h_im);
				if (got.sx_re !== want.sx_re) report_mismatch("slope_x_re", got.sx_re, want.sx_re);
				if (got.sx_im !== want.sx_im) report_mismatch("slope_x_im", got.sx_im, want.sx_im);
				if (got.sz_re !== want.sz_re) report_mismatch("slope_z_re", got.sz_re, want.sz_re);
				if (got.sz_im !== want.sz_im) report_mismatch("slope_z_im", got.sz_im, want.sz_im);
				if (got.dx_re !== want.dx_re) report_mismatch("disp_x_re", got.dx_re, want.dx_re);
				if (got.dx_im !== want.dx_im) report_mismatch("disp_x_im", got.dx_im, want.dx_im);
				if (got.dz_re !== want.dz_re) report_mismatch("disp_z_re", got.dz_re, want.dz_re);
				if (got.dz_im !== want.dz_im) report_mismatch("disp_z_im", got.dz_im, want.dz_im);
			end
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		case (idx)
			REG_STEP_X: step_x_q = val;
			REG_STEP_Z: step_z_q = val;
			REG_TIME:   time_q   = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until the pipeline is empty and every result has come
	task automatic drain();
		while (pending_bins.size() > 0 || s_tvalid || wave_expect.size() > 0)
			@(negedge clk);
		repeat (LATENCY + 20) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_amp();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_bin(input logic [7:0] col, input logic [7:0] row,
			input logic [31:0] a, input logic [31:0] b2, input logic [31:0] c2,
			input logic [31:0] d);
		bin_t b;
		b.col = col; b.row = row;
		b.h0_re = a; b.h0_im = b2; b.mir_re = c2; b.mir_im = d;
		pending_bins.push_back(b);
	endtask

	task automatic add_random(input int n);
		repeat (n)
			add_bin(8'($urandom), 8'($urandom), rand_amp(), rand_amp(), rand_amp(),
				rand_amp());
	endtask

	initial begin
		idle_on     = 1'b1;
		hold_tokens = 0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_STEP_X;
		cfg_data    = '0;
		step_x_q    = 32'd1647099;
		step_z_q    = 32'd1647099;
		time_q      = 32'd0;
		arst_n      = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, grid extremes and zero length
		add_bin(8'd128, 8'd128, 32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000);
		add_bin(8'd0,   8'd0,   32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
		add_bin(8'd255, 8'd255, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		add_bin(8'd127, 8'd129, 32'hFFFFFFFF, 32'h00000001, 32'h0, 32'h0);
		add_bin(8'd255, 8'd0,   32'h12345678, 32'hEDCBA987, 32'h0F0F0F0F, 32'hF0F0F0F0);
		drain();

		// directed: largest step and time
		reg_write(REG_STEP_X, 32'hFFFFFFFF);
		reg_write(REG_STEP_Z, 32'hFFFFFFFF);
		reg_write(REG_TIME,   32'hFFFFFFFF);
		add_bin(8'd0,   8'd255, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		add_bin(8'd255, 8'd0,   32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		add_bin(8'd128, 8'd128, 32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'hFFFFFFFF);
		add_bin(8'd129, 8'd127, 32'h00010000, 32'h00000000, 32'h00000000, 32'h00010000);
		drain();

		// zero step along x with smallest step along z, ignored index
		reg_write(REG_STEP_X, 32'd0);
		reg_write(REG_STEP_Z, 32'd1);
		reg_write(REG_TIME,   32'h00018000);
		reg_write(REG_NONE,   32'hDEADBEEF);
		add_bin(8'd0,   8'd0,   32'h00010000, 32'h00020000, 32'h00030000, 32'h00040000);
		add_bin(8'd200, 8'd255, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000);
		add_bin(8'd128, 8'd0,   32'h00010000, 32'hFFFF0000, 32'h00008000, 32'h00000000);
		add_random(8);
		drain();

		// random settings; long receiver hold-off while the sender keeps going
		for (int ph = 0; ph < 6; ph++) begin
			reg_write(REG_STEP_X, (ph == 1) ? 32'h00000001 : $urandom);
			reg_write(REG_STEP_Z, (ph == 2) ? 32'd1647099 : $urandom_range(1, 32'h0FFFFFFF));
			reg_write(REG_TIME,   (ph == 3) ? 32'h0 : $urandom);
			idle_on = (ph != 4);
			if (ph == 4)
				hold_tokens++;
			add_random(90);
			drain();
		end

		if (err_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
